// ----- rtl/lfra_pkg.sv -----
`default_nettype none

package lfra_pkg;

  localparam int unsigned CUSTOMERS = 1024;
  localparam int unsigned CUST_W    = $clog2(CUSTOMERS);
  localparam int unsigned ROOM_W    = 7;
  localparam int unsigned ROOMS_DEF = 64;

  localparam logic [ROOM_W-1:0] LIMIT_RESET = ROOM_W'(64);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DEPART = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_ROOM = 2'd2;

  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_ROOM_LIMIT = 1'b0;

  typedef struct packed {
    logic              opcode;
    logic [CUST_W-1:0] customer_id;
  } in_item_t;

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [ROOM_W-1:0] rooms_in_use;
    logic [ROOM_W-1:0] peak_in_use;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic              found;
    logic [ROOM_W-1:0] room;
  } pick_t;

endpackage

`default_nettype wire

// ----- rtl/lfra_pick.sv -----
`default_nettype none

module lfra_pick
  import lfra_pkg::*;
#(
  parameter int unsigned ROOMS = ROOMS_DEF
) (
  input  logic [ROOMS-1:0] cand_i,
  output logic [ROOMS-1:0] onehot_o,
  output pick_t            pick_o
);

  assign onehot_o = cand_i & (~cand_i + ROOMS'(1));

  always_comb begin
    pick_o.found = |cand_i;
    pick_o.room  = '0;
    for (int r = 0; r < ROOMS; r++) begin
      if (onehot_o[r]) begin
        pick_o.room = pick_o.room | ROOM_W'(r + 1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lowest_free_room_allocator_top.sv -----
// Room allocator: each arrival transfer gets the lowest free room from 1 to
// min(room_limit, ROOMS) and each departure frees the customer's room; every
// event gives one result transfer with room, busy count, peak and status.
// The customer table is a 1024 x 7 synchronous RAM. After reset the block
// clears all 1024 entries with in_ready_o low (register writes still work).
// An event is read from the RAM at its input transfer into the stage registers,
// then decided and written back when the stage advances, with forwarding between
// neighbors. Its result enters the output register as the stage advances. The block takes
// one event per cycle while results drain; a held result stalls the input.
`default_nettype none

module lowest_free_room_allocator_top
  import lfra_pkg::*;
#(
  parameter int unsigned ROOMS = ROOMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [ROOM_W-1:0] mem_q [CUSTOMERS];
  logic [ROOM_W-1:0] rdata_q;
  logic              mem_we;
  logic [CUST_W-1:0] mem_waddr;
  logic [ROOM_W-1:0] mem_wdata;

  logic              clr_q, clr_d;
  logic [CUST_W-1:0] clr_addr_q, clr_addr_d;

  logic [ROOM_W-1:0] room_limit_q, room_limit_d;
  logic [ROOMS-1:0]  free_q, free_d;
  logic [ROOM_W-1:0] busy_q, busy_d;
  logic [ROOM_W-1:0] peak_q, peak_d;

  logic              busy_stg_q, busy_stg_d;
  logic              op_q;
  logic [CUST_W-1:0] cid_q;
  logic              fwd_q, fwd_d;
  logic [ROOM_W-1:0] fwd_data_q;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              accept;
  logic              advance;
  logic              cfg_wr;
  logic [ROOM_W-1:0] held;
  logic [ROOMS-1:0]  allowed;
  logic [ROOMS-1:0]  cand;
  logic [ROOMS-1:0]  pick_hot;
  logic [ROOMS-1:0]  rel_hot;
  pick_t             pick;
  logic [ROOM_W-1:0] new_entry;
  logic              entry_chg;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_ROOM_LIMIT) ? {{(32 - ROOM_W){1'b0}}, room_limit_q} : '0;
  assign room_limit_d = (cfg_wr && paddr[2] == REG_ROOM_LIMIT) ? pwdata[ROOM_W-1:0]
                                                                 : room_limit_q;

  assign advance    = busy_stg_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~clr_q & (~busy_stg_q | advance);
  assign accept     = in_valid_i & in_ready_o;

  assign held = fwd_q ? fwd_data_q : rdata_q;

  always_comb begin
    for (int r = 0; r < ROOMS; r++) begin
      allowed[r] = ROOM_W'(r) < room_limit_q;
      rel_hot[r] = held == ROOM_W'(r + 1);
    end
  end

  assign cand = free_q & allowed;

  lfra_pick #(
    .ROOMS(ROOMS)
  ) u_pick (
    .cand_i  (cand),
    .onehot_o(pick_hot),
    .pick_o  (pick)
  );

  always_comb begin
    free_d          = free_q;
    busy_d          = busy_q;
    peak_d          = peak_q;
    new_entry       = held;
    entry_chg       = 1'b0;
    out_d           = out_q;
    out_d.room      = '0;
    out_d.status    = STATUS_OK;
    if (op_q == OP_ARRIVE) begin
      if (held != '0) begin
        out_d.room = held;
      end else if (pick.found) begin
        out_d.room = pick.room;
        free_d     = free_q & ~pick_hot;
        new_entry  = pick.room;
        entry_chg  = 1'b1;
        busy_d     = busy_q + ROOM_W'(1);
        if (busy_d > peak_q) begin
          peak_d = busy_d;
        end
      end else begin
        out_d.status = STATUS_FULL;
      end
    end else begin
      if (held == '0) begin
        out_d.status = STATUS_NO_ROOM;
      end else begin
        out_d.room = held;
        free_d     = free_q | rel_hot;
        new_entry  = '0;
        entry_chg  = 1'b1;
        if (busy_q != '0) begin
          busy_d = busy_q - ROOM_W'(1);
        end
      end
    end
    out_d.rooms_in_use = busy_d;
    out_d.peak_in_use  = peak_d;
    if (!advance) begin
      free_d = free_q;
      busy_d = busy_q;
      peak_d = peak_q;
      out_d  = out_q;
    end
  end

  assign mem_we    = clr_q | (advance & entry_chg);
  assign mem_waddr = clr_q ? clr_addr_q : cid_q;
  assign mem_wdata = clr_q ? '0 : new_entry;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= mem_q[in_data_i.customer_id];
      op_q    <= in_data_i.opcode;
      cid_q   <= in_data_i.customer_id;
    end
    if (accept && advance) begin
      fwd_data_q <= new_entry;
    end
    out_q <= out_d;
  end

  assign clr_d      = clr_q & (clr_addr_q != CUST_W'(CUSTOMERS - 1));
  assign clr_addr_d = clr_q ? clr_addr_q + CUST_W'(1) : clr_addr_q;
  assign busy_stg_d = accept | (busy_stg_q & ~advance);
  assign fwd_d      = accept ? (advance && cid_q == in_data_i.customer_id)
                             : (fwd_q & ~advance);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= 1'b1;
      clr_addr_q   <= '0;
      room_limit_q <= LIMIT_RESET;
      free_q       <= '1;
      busy_q       <= '0;
      peak_q       <= '0;
      busy_stg_q   <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_q        <= clr_d;
      clr_addr_q   <= clr_addr_d;
      room_limit_q <= room_limit_d;
      free_q       <= free_d;
      busy_q       <= busy_d;
      peak_q       <= peak_d;
      busy_stg_q   <= busy_stg_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // busy count tracks the number of cleared bits in the free map
  a_busy_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~free_q) == busy_q)
    else $error("busy count does not match free map");

  a_peak_covers_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= busy_q)
    else $error("peak below busy count");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_stg_q))
    else $error("result without an event in flight");

  a_fwd_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> busy_stg_q)
    else $error("forwarding flag without an event in flight");

  a_no_event_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !busy_stg_q && !out_valid_q)
    else $error("event active during table clear");

endmodule

`default_nettype wire
